### design/i2cmbs_pkg.sv
package i2cmbs_pkg;

  // Command codes carried in each request.
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam int BYTE_BITS = 8;
  localparam int STEP_W    = 6;

  // Step numbers that mark the end of the bit loops.
  localparam logic [STEP_W-1:0] WR_RELEASE_STEP = STEP_W'(3 * BYTE_BITS);
  localparam logic [STEP_W-1:0] WR_ACK_STEP     = STEP_W'(3 * BYTE_BITS + 1);
  localparam logic [STEP_W-1:0] RD_ACK_STEP     = STEP_W'(2 * BYTE_BITS);
  localparam logic [STEP_W-1:0] RD_CLK_STEP     = STEP_W'(2 * BYTE_BITS + 1);
  localparam logic [STEP_W-1:0] STOP_DONE_STEP  = STEP_W'(4);

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd250;

  // Configuration register addresses (word index taken from the byte address).
  localparam logic REG_PHASE_TICKS = 1'b0;

  typedef struct packed {
    logic [STEP_W-1:0]    step;
    logic [2:0]           cmd;
    logic [BYTE_BITS-1:0] shift;
    logic                 ack_choice;
    logic                 scl;
    logic                 sda;
    logic                 sda_en;
    logic                 nack;
    logic [BYTE_BITS-1:0] read_hold;
  } seq_state_t;

  // Residue modulo 3 of a step number: 2^k mod 3 alternates 1, 2.
  function automatic logic [1:0] mod3_step(input logic [STEP_W-1:0] v);
    logic [3:0] sum;
    logic [1:0] res;
    sum = 4'(v[0]) + 4'(v[2]) + 4'(v[4])
        + 4'({v[1], 1'b0}) + 4'({v[3], 1'b0}) + 4'({v[5], 1'b0});
    unique case (sum)
      4'd0, 4'd3, 4'd6, 4'd9: res = 2'd0;
      4'd1, 4'd4, 4'd7:       res = 2'd1;
      4'd2, 4'd5, 4'd8:       res = 2'd2;
      default:                res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

### design/i2cmbs_group.sv
module i2cmbs_group (
  input  i2cmbs_pkg::seq_state_t st,
  input  logic                   sda_in,
  output i2cmbs_pkg::seq_state_t st_out,
  output logic                   fin
);
  import i2cmbs_pkg::*;

  logic [1:0] phase;

  assign phase = mod3_step(st.step);

  // Applies the pin actions of the group selected by command and step.
  always_comb begin
    st_out = st;
    fin    = 1'b0;
    unique case (st.cmd)
      CMD_START: begin
        unique case (st.step)
          6'd0:    st_out.sda = 1'b1;
          6'd1:    st_out.scl = 1'b1;
          6'd2:    st_out.sda = 1'b0;
          6'd3:    st_out.scl = 1'b0;
          default: fin = 1'b1;
        endcase
      end
      CMD_STOP: begin
        if (st.step >= STOP_DONE_STEP) begin
          fin = 1'b1;
        end else begin
          unique case (st.step[1:0])
            2'd1:    st_out.sda = 1'b0;
            2'd2:    st_out.scl = 1'b1;
            2'd3:    st_out.sda = 1'b1;
            default: st_out.sda = st.sda;
          endcase
        end
      end
      CMD_WRITE: begin
        if (st.step < WR_RELEASE_STEP) begin
          unique case (phase)
            2'd0: begin
              if (st.step == '0) begin
                st_out.sda_en = 1'b1;
              end else begin
                st_out.shift = {st.shift[BYTE_BITS-2:0], 1'b0};
              end
              st_out.scl = 1'b0;
            end
            2'd1:    st_out.sda = st.shift[BYTE_BITS-1];
            default: st_out.scl = 1'b1;
          endcase
        end else if (st.step == WR_RELEASE_STEP) begin
          st_out.sda_en = 1'b0;
          st_out.scl    = 1'b0;
        end else if (st.step == WR_ACK_STEP) begin
          st_out.scl  = 1'b1;
          st_out.nack = sda_in;
          fin         = sda_in;
        end else begin
          st_out.scl    = 1'b0;
          st_out.sda_en = 1'b1;
          fin           = 1'b1;
        end
      end
      CMD_READ: begin
        if (st.step == '0) begin
          st_out.sda_en = 1'b0;
        end else if (st.step < RD_ACK_STEP) begin
          if (st.step[0]) begin
            st_out.shift = {st.shift[BYTE_BITS-2:0], sda_in};
            st_out.scl   = 1'b1;
          end else begin
            st_out.scl = 1'b0;
          end
        end else if (st.step == RD_ACK_STEP) begin
          st_out.scl    = 1'b0;
          st_out.sda_en = 1'b1;
          st_out.sda    = ~st.ack_choice;
        end else if (st.step == RD_CLK_STEP) begin
          st_out.scl = 1'b1;
        end else begin
          st_out.scl       = 1'b0;
          st_out.read_hold = st.shift;
          fin              = 1'b1;
        end
      end
      default: fin = 1'b1;
    endcase
  end

endmodule

### design/i2c_master_byte_sequencer.sv
// Byte-level I2C master sequencer. Each request on the in_ stream is one tick of time: it may
// carry a command (start, stop, write byte, read byte) that is taken only while the sequencer
// is idle, together with the sampled SDA level. Every request yields exactly one result on the
// out_ stream with the SCL/SDA levels to drive, the SDA drive enable, busy, a one-tick done
// flag, the last read byte and the acknowledge status of the last write. Consecutive pin
// actions of a command are spaced by phase_ticks ticks (APB register at byte address 0, reset
// 250, zero acts as one); write it only while no request is in flight, and a write during a
// command takes effect at the next wait comparison. The block takes one request per clock
// cycle while in_tready is high and presents its result on out_tdata through one input
// register and one result register, with the whole tick update (timer, step decoder, shift
// register) in between. A stalled result stops the input register from advancing, and
// in_tready drops only when both stages are full and the result is stalled.
module i2c_master_byte_sequencer #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, lowest bit up: command[2:0], data_byte[10:3], send_ack[11], sda_in[12], zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // out_tdata, lowest bit up: scl_level[0], sda_level[1], sda_drive_enable[2], busy_res[3],
  // done_res[4], read_data[12:5], nack_received[13], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import i2cmbs_pkg::*;

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  // Configuration register.
  logic [15:0] phase_ticks_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_PHASE_TICKS) begin
      phase_ticks_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_PHASE_TICKS) ? {16'd0, phase_ticks_r} : 32'd0;

  // Two-stage pipeline: input register, then result register.
  logic        s1_valid_r;
  logic [15:0] s1_data_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        advance;
  logic        fire;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
    end
  end

  // Fields of the registered request.
  logic [2:0]           in_cmd;
  logic [BYTE_BITS-1:0] in_byte;
  logic                 in_ack;
  logic                 in_sda;

  assign in_cmd  = s1_data_r[2:0];
  assign in_byte = s1_data_r[10:3];
  assign in_ack  = s1_data_r[11];
  assign in_sda  = s1_data_r[12];

  // Sequencer state.
  seq_state_t             state_r;
  seq_state_t             state_nxt;
  logic [TIMER_WIDTH-1:0] timer_r;
  logic [TIMER_WIDTH-1:0] timer_nxt;

  // Wait limit: zero counts as one, and anything beyond the timer range is clamped.
  logic [15:0]            pt_eff;
  logic [CW-1:0]          lim_wide;
  logic [CW-1:0]          mask_wide;
  logic [TIMER_WIDTH-1:0] lim;
  logic [TIMER_WIDTH-1:0] tick;

  assign pt_eff    = (phase_ticks_r == 16'd0) ? 16'd1 : phase_ticks_r;
  assign lim_wide  = CW'(pt_eff);
  assign mask_wide = CW'({TIMER_WIDTH{1'b1}});
  assign lim       = (lim_wide > mask_wide) ? TIMER_WIDTH'(mask_wide)
                                            : TIMER_WIDTH'(lim_wide);
  assign tick      = timer_r + TIMER_WIDTH'(1);

  // When idle the first group runs on the accepting tick with the freshly loaded command.
  logic       idle;
  logic       cmd_ok;
  seq_state_t grp_in;
  seq_state_t grp_out;
  logic       grp_fin;

  assign idle   = (state_r.cmd == CMD_NONE);
  assign cmd_ok = (in_cmd >= CMD_START) && (in_cmd <= CMD_READ);

  always_comb begin
    grp_in = state_r;
    if (idle) begin
      grp_in.cmd        = in_cmd;
      grp_in.shift      = (in_cmd == CMD_WRITE) ? in_byte : '0;
      grp_in.ack_choice = in_ack;
      grp_in.step       = '0;
    end
  end

  i2cmbs_group u_group (
    .st     (grp_in),
    .sda_in (in_sda),
    .st_out (grp_out),
    .fin    (grp_fin)
  );

  logic done;

  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    done      = 1'b0;
    if (idle) begin
      if (cmd_ok) begin
        state_nxt      = grp_out;
        state_nxt.step = STEP_W'(1);
        timer_nxt      = '0;
      end
    end else if (tick >= lim) begin
      timer_nxt = '0;
      state_nxt = grp_out;
      if (grp_fin) begin
        state_nxt.cmd  = CMD_NONE;
        state_nxt.step = '0;
        done           = 1'b1;
      end else begin
        state_nxt.step = state_r.step + STEP_W'(1);
      end
    end else begin
      timer_nxt = tick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{step: '0, cmd: CMD_NONE, shift: '0, ack_choice: 1'b0, scl: 1'b1,
                   sda: 1'b1, sda_en: 1'b1, nack: 1'b0, read_hold: '0};
      timer_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
    end
  end

  // The result register holds the pin and status view after this tick's update.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {2'b00, state_nxt.nack, state_nxt.read_hold, done,
                     (state_nxt.cmd != CMD_NONE), state_nxt.sda_en, state_nxt.sda,
                     state_nxt.scl};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A finishing tick never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[3]))
    else $error("done reported together with busy");

  // An idle sequencer sits at step zero with a cleared timer.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.cmd == CMD_NONE) |-> (state_r.step == '0 && timer_r == '0))
    else $error("idle sequencer with stale step or timer");

  // The step counter never runs past the longest command.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.step <= WR_ACK_STEP + STEP_W'(1))
    else $error("sequence step out of range");

  // Done is only produced by a state update that left a busy sequencer idle.
  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && done) |=> (state_r.cmd == CMD_NONE && $past(state_r.cmd) != CMD_NONE))
    else $error("done without a finishing command");

endmodule
